// ----- hw/rtl/fjp_pkg.sv -----
package fjp_pkg;

  typedef enum logic [2:0] {
    ST_PARSING  = 3'd0,
    ST_OK       = 3'd1,
    ST_NOT_OBJ  = 3'd2,
    ST_BAD_PAIR = 3'd3,
    ST_BAD_SEP  = 3'd4,
    ST_TRAILING = 3'd5
  } status_t;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       end_marker;
  } text_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       char_valid;
    logic       in_key;
    logic       string_done;
    status_t    status;
  } result_t;

endpackage

// ----- hw/rtl/fjp_text_if.sv -----
interface fjp_text_if
  import fjp_pkg::*;
();
  logic  valid;
  logic  ready;
  text_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- hw/rtl/fjp_result_if.sv -----
interface fjp_result_if
  import fjp_pkg::*;
();
  logic    valid;
  logic    ready;
  result_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- hw/rtl/flat_json_object_parser.sv -----
// channel  | role  | word
// ---------+-------+-----------------------------------------------
// text     | sink  | byte_value, end_marker
// result   | source| out_char, char_valid, in_key, string_done, status
//
// one word in, one word out; one byte per clock sustained while result is ready
// a word passes through the input register, then parse logic into the output register
// the parse state advances when a word moves into the output register
// rst (synchronous) clears both stages, the phase and the latched error
// a stalled result holds; the input register then takes a word only while it is empty
module flat_json_object_parser
  import fjp_pkg::*;
(
  input  logic           clk,
  input  logic           rst,
  fjp_text_if.sink       text,
  fjp_result_if.source   result
);

  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;

  typedef enum logic [10:0] {
    PH_OPEN      = 11'b000_0000_0001,
    PH_FIRST     = 11'b000_0000_0010,
    PH_KEY       = 11'b000_0000_0100,
    PH_KEY_ESC   = 11'b000_0000_1000,
    PH_COLON     = 11'b000_0001_0000,
    PH_VALUE_Q   = 11'b000_0010_0000,
    PH_VALUE     = 11'b000_0100_0000,
    PH_VALUE_ESC = 11'b000_1000_0000,
    PH_SEP       = 11'b001_0000_0000,
    PH_NEXT_KEY  = 11'b010_0000_0000,
    PH_DONE      = 11'b100_0000_0000
  } phase_t;

  logic    s1_valid;
  text_t   s1_data;
  logic    out_valid;
  result_t out_data;
  result_t out_next;
  phase_t  phase;
  phase_t  phase_next;
  status_t err;
  status_t err_next;
  logic    out_take;
  logic    blank;
  logic    esc_ok;
  logic [7:0] esc_char;
  logic [7:0] b;

  assign out_take     = !out_valid || result.ready;
  assign text.ready   = !s1_valid || out_take;
  assign result.valid = out_valid;
  assign result.data  = out_data;

  assign b     = s1_data.byte_value;
  assign blank = (b == 8'h20) || (b >= 8'h09 && b <= 8'h0D);

  always_comb begin
    esc_ok   = 1'b1;
    esc_char = b;
    unique case (b)
      CH_QUOTE, CH_BSLASH, 8'h2F: esc_char = b;
      8'h62:   esc_char = 8'h08;
      8'h66:   esc_char = 8'h0C;
      8'h6E:   esc_char = 8'h0A;
      8'h72:   esc_char = 8'h0D;
      8'h74:   esc_char = 8'h09;
      default: esc_ok = 1'b0;
    endcase
  end

  always_comb begin
    phase_next = phase;
    err_next   = err;
    out_next   = '{out_char: 8'd0, char_valid: 1'b0, in_key: 1'b0,
                   string_done: 1'b0, status: ST_PARSING};
    if (s1_data.end_marker) begin
      phase_next = PH_OPEN;
      err_next   = ST_PARSING;
      if (err != ST_PARSING) begin
        out_next.status = err;
      end else begin
        unique case (phase)
          PH_DONE: out_next.status = ST_OK;
          PH_OPEN: out_next.status = ST_NOT_OBJ;
          PH_SEP:  out_next.status = ST_BAD_SEP;
          default: out_next.status = ST_BAD_PAIR;
        endcase
      end
    end else if (err == ST_PARSING) begin
      unique case (phase)
        PH_OPEN: begin
          if (b == CH_LBRACE) phase_next = PH_FIRST;
          else if (!blank) err_next = ST_NOT_OBJ;
        end
        PH_FIRST: begin
          if (b == CH_RBRACE) phase_next = PH_DONE;
          else if (b == CH_QUOTE) phase_next = PH_KEY;
          else if (!blank) err_next = ST_BAD_PAIR;
        end
        PH_KEY, PH_VALUE: begin
          if (b == CH_QUOTE) begin
            out_next.string_done = 1'b1;
            out_next.in_key      = (phase == PH_KEY);
            phase_next = (phase == PH_KEY) ? PH_COLON : PH_SEP;
          end else if (b == CH_BSLASH) begin
            phase_next = (phase == PH_KEY) ? PH_KEY_ESC : PH_VALUE_ESC;
          end else begin
            out_next.out_char   = b;
            out_next.char_valid = 1'b1;
            out_next.in_key     = (phase == PH_KEY);
          end
        end
        PH_KEY_ESC, PH_VALUE_ESC: begin
          if (esc_ok) begin
            out_next.out_char   = esc_char;
            out_next.char_valid = 1'b1;
            out_next.in_key     = (phase == PH_KEY_ESC);
            phase_next = (phase == PH_KEY_ESC) ? PH_KEY : PH_VALUE;
          end else begin
            err_next = ST_BAD_PAIR;
          end
        end
        PH_COLON: begin
          if (b == CH_COLON) phase_next = PH_VALUE_Q;
          else if (!blank) err_next = ST_BAD_PAIR;
        end
        PH_VALUE_Q: begin
          if (b == CH_QUOTE) phase_next = PH_VALUE;
          else if (!blank) err_next = ST_BAD_PAIR;
        end
        PH_SEP: begin
          if (b == CH_RBRACE) phase_next = PH_DONE;
          else if (b == CH_COMMA) phase_next = PH_NEXT_KEY;
          else if (!blank) err_next = ST_BAD_SEP;
        end
        PH_NEXT_KEY: begin
          if (b == CH_QUOTE) phase_next = PH_KEY;
          else if (!blank) err_next = ST_BAD_PAIR;
        end
        PH_DONE: begin
          if (!blank) err_next = ST_TRAILING;
        end
        default: err_next = ST_BAD_PAIR;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (text.ready) begin
      s1_valid <= text.valid;
    end
    if (text.valid && text.ready) begin
      s1_data <= text.data;
    end
  end

  // state moves with the word entering the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      phase     <= PH_OPEN;
      err       <= ST_PARSING;
    end else if (out_take) begin
      out_valid <= s1_valid;
      if (s1_valid) begin
        phase <= phase_next;
        err   <= err_next;
      end
    end
    if (out_take && s1_valid) begin
      out_data <= out_next;
    end
  end

endmodule
